@@ src/velocity_slew_limiter_assert.svh @@
// Assertion macros shared by the velocity slew limiter RTL.
// No dependencies; include from inside a module body.
`ifndef VELOCITY_SLEW_LIMITER_ASSERT_SVH
`define VELOCITY_SLEW_LIMITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VSL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("velocity_slew_limiter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define VSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("velocity_slew_limiter: next-cycle check failed");

`endif

@@ src/vsl_pkg.sv @@
// Types and constants for the velocity slew limiter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vsl_pkg;

   localparam int VEL_W       = 16;   // Q8.8 velocity
   localparam int LIMIT_W     = 15;   // speed and acceleration limits
   localparam int DT_W        = 16;   // Q0.16 seconds
   localparam int CSR_INDEX_W = 8;

   localparam logic [LIMIT_W-1:0] SPEED_RESET = '1;
   localparam logic [LIMIT_W-1:0] ACCEL_RESET = '0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAX_LINEAR_SPEED  = 8'd0,
      REG_MAX_ANGULAR_SPEED = 8'd1,
      REG_MAX_LINEAR_ACCEL  = 8'd2,
      REG_MAX_ANGULAR_ACCEL = 8'd3
   } csr_reg_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] max_speed;
      logic [LIMIT_W-1:0] max_accel;
   } axis_cfg_type;

endpackage

@@ src/vsl_axis.sv @@
// One axis of the slew limiter: zero non-finite input, clamp, slew-limit.
// Depends on vsl_pkg.
`timescale 1ns / 1ps

module vsl_axis import vsl_pkg::*; (
   input  axis_cfg_type              cfg,
   input  logic signed [VEL_W-1:0]   request,
   input  logic                      not_finite,
   input  logic        [DT_W-1:0]    step_time,
   input  logic signed [VEL_W-1:0]   prev,
   input  logic                      have_prev,
   output logic signed [VEL_W-1:0]   command
);

   localparam int PROD_W = LIMIT_W + DT_W;

   logic signed [VEL_W-1:0]  raw;
   logic signed [VEL_W-1:0]  lim;
   logic signed [VEL_W-1:0]  want;
   logic        [PROD_W-1:0] product;
   logic signed [VEL_W:0]    step;
   logic signed [VEL_W:0]    diff;
   logic signed [VEL_W:0]    diff_lim;
   logic signed [VEL_W:0]    sum;
   logic                     slew_on;

   always_comb begin
      raw = not_finite ? '0 : request;
      lim = signed'({1'b0, cfg.max_speed});
      if (raw > lim) begin
         want = lim;
      end else if (raw < -lim) begin
         want = -lim;
      end else begin
         want = raw;
      end

      // Q8.8 accel times Q0.16 dt, truncated back to Q8.8
      product  = PROD_W'(cfg.max_accel) * PROD_W'(step_time);
      step     = signed'({2'b00, product[PROD_W-1:DT_W]});
      diff     = {want[VEL_W-1], want} - {prev[VEL_W-1], prev};
      if (diff > step) begin
         diff_lim = step;
      end else if (diff < -step) begin
         diff_lim = -step;
      end else begin
         diff_lim = diff;
      end
      sum     = {prev[VEL_W-1], prev} + diff_lim;
      slew_on = have_prev && (cfg.max_accel != '0) && (step_time != '0);
      command = slew_on ? sum[VEL_W-1:0] : want;
   end

endmodule

@@ src/velocity_slew_limiter.sv @@
// Velocity slew limiter top level: handshakes, registers, two axis units.
// Depends on vsl_pkg, vsl_axis and velocity_slew_limiter_assert.svh.
`timescale 1ns / 1ps

// Takes one command beat per clock cycle, back to back, while req_stall
// is low. An accepted beat lands in an input register; once the output
// register is free, the limited result is written to it and rsp_valid
// rises. Between the input and output registers lies one combinational
// pass per axis: a zero/clamp stage, a 15x16 multiply for the step bound,
// one subtract-and-compare and one add. req_stall rises only when both the
// input and output registers are full and rsp_stall is held. Restart on a
// beat forgets the previous output before that beat is handled. The CSR
// port never stalls (csr_ready is always high); indexes above three are
// dropped, and limits must only be written while the block is idle.
module velocity_slew_limiter import vsl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // command beats in
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [VEL_W-1:0]  req_linear_request,
   input  logic signed [VEL_W-1:0]  req_angular_request,
   input  logic                     req_linear_not_finite,
   input  logic                     req_angular_not_finite,
   input  logic        [DT_W-1:0]   req_step_time,
   input  logic                     req_restart,
   // limited commands out
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [VEL_W-1:0]  rsp_linear_command,
   output logic signed [VEL_W-1:0]  rsp_angular_command,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [LIMIT_W-1:0]       csr_wdata
);

`include "velocity_slew_limiter_assert.svh"

   // limit registers
   logic [LIMIT_W-1:0] max_linear_speed_ff,  max_linear_speed_in;
   logic [LIMIT_W-1:0] max_angular_speed_ff, max_angular_speed_in;
   logic [LIMIT_W-1:0] max_linear_accel_ff,  max_linear_accel_in;
   logic [LIMIT_W-1:0] max_angular_accel_ff, max_angular_accel_in;

   // input register
   logic                    in_valid_ff, in_valid_in;
   logic signed [VEL_W-1:0] in_linear_ff, in_angular_ff;
   logic                    in_lin_nf_ff, in_ang_nf_ff;
   logic        [DT_W-1:0]  in_dt_ff;
   logic                    in_restart_ff;

   // output register and previous-output state
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VEL_W-1:0] rsp_linear_ff, rsp_angular_ff;
   logic signed [VEL_W-1:0] last_linear_ff, last_angular_ff;
   logic                    have_last_ff;

   logic                    req_take;
   logic                    out_free;
   logic                    advance;
   logic                    have_prev;
   logic signed [VEL_W-1:0] linear_cmd, angular_cmd;
   axis_cfg_type            linear_cfg, angular_cfg;
   logic                    history_match;
   logic                    history_zero;

   // ---------------------------------------------------------------
   // Handshake: the output register frees when empty or being taken;
   // the input register then advances, and may refill in the same cycle.
   // ---------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Register writes: decode the index, drop anything beyond the list.
   // ---------------------------------------------------------------
   always_comb begin
      max_linear_speed_in  = max_linear_speed_ff;
      max_angular_speed_in = max_angular_speed_ff;
      max_linear_accel_in  = max_linear_accel_ff;
      max_angular_accel_in = max_angular_accel_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MAX_LINEAR_SPEED:  max_linear_speed_in  = csr_wdata;
            REG_MAX_ANGULAR_SPEED: max_angular_speed_in = csr_wdata;
            REG_MAX_LINEAR_ACCEL:  max_linear_accel_in  = csr_wdata;
            REG_MAX_ANGULAR_ACCEL: max_angular_accel_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_linear_speed_ff  <= SPEED_RESET;
         max_angular_speed_ff <= SPEED_RESET;
         max_linear_accel_ff  <= ACCEL_RESET;
         max_angular_accel_ff <= ACCEL_RESET;
      end else begin
         max_linear_speed_ff  <= max_linear_speed_in;
         max_angular_speed_ff <= max_angular_speed_in;
         max_linear_accel_ff  <= max_linear_accel_in;
         max_angular_accel_ff <= max_angular_accel_in;
      end
   end

   // ---------------------------------------------------------------
   // Input register: hold the beat until it moves on.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_linear_ff  <= req_linear_request;
         in_angular_ff <= req_angular_request;
         in_lin_nf_ff  <= req_linear_not_finite;
         in_ang_nf_ff  <= req_angular_not_finite;
         in_dt_ff      <= req_step_time;
         in_restart_ff <= req_restart;
      end
   end

   // ---------------------------------------------------------------
   // Axis units. Restart on the beat makes it behave as the first one.
   // ---------------------------------------------------------------
   assign have_prev   = have_last_ff && !in_restart_ff;
   assign linear_cfg  = '{max_speed: max_linear_speed_ff,  max_accel: max_linear_accel_ff};
   assign angular_cfg = '{max_speed: max_angular_speed_ff, max_accel: max_angular_accel_ff};

   vsl_axis u_linear (
      .cfg        (linear_cfg),
      .request    (in_linear_ff),
      .not_finite (in_lin_nf_ff),
      .step_time  (in_dt_ff),
      .prev       (last_linear_ff),
      .have_prev  (have_prev),
      .command    (linear_cmd)
   );

   vsl_axis u_angular (
      .cfg        (angular_cfg),
      .request    (in_angular_ff),
      .not_finite (in_ang_nf_ff),
      .step_time  (in_dt_ff),
      .prev       (last_angular_ff),
      .have_prev  (have_prev),
      .command    (angular_cmd)
   );

   // ---------------------------------------------------------------
   // Output register and previous-output state advance together.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         have_last_ff    <= 1'b0;
         last_linear_ff  <= '0;
         last_angular_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            have_last_ff    <= 1'b1;
            last_linear_ff  <= linear_cmd;
            last_angular_ff <= angular_cmd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_linear_ff  <= linear_cmd;
         rsp_angular_ff <= angular_cmd;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_linear_command  = rsp_linear_ff;
   assign rsp_angular_command = rsp_angular_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   assign history_match = (rsp_linear_ff == last_linear_ff) &&
                          (rsp_angular_ff == last_angular_ff);
   assign history_zero  = (last_linear_ff == '0) && (last_angular_ff == '0);

   `VSL_ASSERT_NEXT(a_advance_fills_output, clock, reset, advance, rsp_valid_ff)
   `VSL_ASSERT_NOW(a_result_implies_history, clock, reset, rsp_valid_ff, have_last_ff)
   `VSL_ASSERT_NOW(a_result_matches_history, clock, reset, rsp_valid_ff, history_match)
   `VSL_ASSERT_NOW(a_no_history_is_zero, clock, reset, !have_last_ff, history_zero)

endmodule
